// File: hdl/lfp_pkg.sv
// Shared types and constants of the lidar frame parser.
package lfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [ByteW-1:0] HeaderReset = 8'h59;

  // Register indexes on the configuration port.
  localparam logic RegHeader = 1'b0;

  // Byte offsets of the little-endian words inside a frame.
  localparam int unsigned DistOfs = 2;
  localparam int unsigned StrOfs = 4;
  localparam int unsigned TempOfs = 6;
  localparam int unsigned TempHiOfs = 7;

  typedef enum logic [2:0] {
    SyncHunt1   = 3'b001,
    SyncHunt2   = 3'b010,
    SyncCollect = 3'b100
  } sync_state_e;

  typedef struct packed {
    logic [WordW-1:0] distance;
    logic [WordW-1:0] strength;
    logic [WordW-1:0] temperature;
    logic             frame_good;
  } result_t;

endpackage

// File: hdl/lfp_if.sv
// Valid/ready channel interfaces for received bytes and parsed frames.
interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic [15:0] strength;
  logic [15:0] temperature;
  logic        frame_good;

  modport source (output valid, output distance, output strength, output temperature,
                  output frame_good, input ready);
  modport sink (input valid, input distance, input strength, input temperature,
                input frame_good, output ready);
endinterface

// File: hdl/lfp_cfg_regs.sv
// APB-style configuration register block holding the header byte.
module lfp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [lfp_pkg::ApbDataW-1:0]  pwdata,
  output logic [lfp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic [lfp_pkg::ByteW-1:0]     header_o
);

  logic [lfp_pkg::ByteW-1:0] header_q, header_d;
  logic                      wr_en;
  logic                      sel_header;

  assign pready = 1'b1;
  assign sel_header = (paddr[2] == lfp_pkg::RegHeader);
  assign wr_en = psel && penable && pwrite && pready && sel_header;

  always_comb begin
    header_d = header_q;
    if (wr_en) begin
      header_d = pwdata[lfp_pkg::ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= lfp_pkg::HeaderReset;
    end else begin
      header_q <= header_d;
    end
  end

  assign prdata = sel_header ? {{(lfp_pkg::ApbDataW - lfp_pkg::ByteW){1'b0}}, header_q}
                             : '0;
  assign header_o = header_q;

endmodule

// File: hdl/lfp_parser.sv
// Input byte register, sync state machine, running checksum and frame byte store.
module lfp_parser #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lfp_pkg::ByteW-1:0] header_i,
  input  logic                      in_valid_i,
  input  logic [lfp_pkg::ByteW-1:0] in_byte_i,
  output logic                      in_ready_o,
  input  logic                      out_free_i,
  output logic                      res_valid_o,
  output lfp_pkg::result_t          res_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES);
  localparam logic [CntW-1:0] Last = CntW'(FRAME_BYTES - 1);
  localparam bit ChkInTemp = (FRAME_BYTES - 1 == lfp_pkg::TempHiOfs);

  logic                       s1_valid_q, s1_valid_d;
  logic [lfp_pkg::ByteW-1:0]  s1_byte_q;
  lfp_pkg::sync_state_e       state_q, state_d, state_tmp;
  logic [CntW-1:0]            cnt_q, cnt_d, idx;
  logic [lfp_pkg::ByteW-1:0]  sum_q, sum_d;
  logic [lfp_pkg::ByteW-1:0]  store_q [lfp_pkg::DistOfs:lfp_pkg::TempHiOfs];
  logic [lfp_pkg::ByteW-1:0]  temp_hi;
  logic                       hdr_match, is_last, emit, advance, accept, good;

  assign hdr_match = (s1_byte_q == header_i);

  always_comb begin
    idx = cnt_q;
    state_tmp = state_q;
    case (state_q)
      lfp_pkg::SyncHunt1: begin
        idx = '0;
        state_tmp = hdr_match ? lfp_pkg::SyncHunt2 : lfp_pkg::SyncHunt1;
      end
      lfp_pkg::SyncHunt2: begin
        state_tmp = hdr_match ? lfp_pkg::SyncCollect : lfp_pkg::SyncHunt1;
      end
      lfp_pkg::SyncCollect: begin
        state_tmp = lfp_pkg::SyncCollect;
      end
      default: begin
        state_tmp = lfp_pkg::SyncCollect;
      end
    endcase
  end

  assign is_last = (idx == Last);
  assign emit = s1_valid_q && is_last && (state_tmp == lfp_pkg::SyncCollect);
  assign advance = s1_valid_q && (!emit || out_free_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept = in_valid_i && in_ready_o;
  assign s1_valid_d = accept || (s1_valid_q && !advance);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (advance) begin
      if (idx == '0) begin
        sum_d = s1_byte_q;
      end else if (idx < Last) begin
        sum_d = 8'(sum_q + s1_byte_q);
      end
      if (is_last) begin
        state_d = lfp_pkg::SyncHunt1;
        cnt_d = '0;
      end else begin
        state_d = state_tmp;
        cnt_d = idx + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q <= lfp_pkg::SyncHunt1;
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      state_q <= state_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_byte_i;
    end
    for (int k = lfp_pkg::DistOfs; k <= lfp_pkg::TempHiOfs; k++) begin
      if (advance && idx == CntW'(k)) begin
        store_q[k] <= s1_byte_q;
      end
    end
  end

  assign temp_hi = ChkInTemp ? s1_byte_q : store_q[lfp_pkg::TempHiOfs];
  assign good = (sum_q == s1_byte_q);

  assign res_valid_o = emit;
  always_comb begin
    res_o = '0;
    res_o.frame_good = good;
    if (good) begin
      res_o.distance = {store_q[lfp_pkg::DistOfs + 1], store_q[lfp_pkg::DistOfs]};
      res_o.strength = {store_q[lfp_pkg::StrOfs + 1], store_q[lfp_pkg::StrOfs]};
      res_o.temperature = {temp_hi, store_q[lfp_pkg::TempOfs]};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Last)
    else $error("frame byte count beyond frame length");

  a_hunt2_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfp_pkg::SyncHunt2 |-> cnt_q == CntW'(1))
    else $error("second header hunt with wrong byte count");

  a_hunt1_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfp_pkg::SyncHunt1 |-> cnt_q <= CntW'(2))
    else $error("first header hunt with unexpected byte count");

  a_emit_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && advance |=> state_q == lfp_pkg::SyncHunt1 && cnt_q == '0)
    else $error("parser did not return to hunting after a frame");

endmodule

// File: hdl/lidar_frame_parser.sv
// Top level of the lidar serial frame parser with result register and config port.
//
//   channel   direction  handshake                payload
//   rx_i      in         rx_i.valid / rx_i.ready  rx_byte
//   res_o     out        res_o.valid / res_o.ready distance, strength, temperature, frame_good
//   APB       in         psel, penable, pready    paddr, pwdata, prdata (header_byte at 0x0)
//
// One byte is accepted every cycle unless a held result stalls the input; each byte is held in
// the input register, and a frame result is loaded into the output register from its checksum byte there.
// Reset is asynchronous and active low; it returns the parser to hunting the first header.
// A result held in the output register stalls the input only when the next byte also
// completes a frame, so bytes keep flowing while a result waits to be taken.
module lidar_frame_parser #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfp_in_if.sink                        rx_i,
  lfp_out_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [lfp_pkg::ApbDataW-1:0]  pwdata,
  output logic [lfp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  logic [lfp_pkg::ByteW-1:0] header;
  logic                      res_valid, out_free, load;
  logic                      out_valid_q, out_valid_d;
  lfp_pkg::result_t          res, out_q;

  lfp_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .header_o (header)
  );

  lfp_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .header_i    (header),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_byte),
    .in_ready_o  (rx_i.ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || res_o.ready;
  assign load = res_valid && out_free;
  assign out_valid_d = load || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.distance = out_q.distance;
  assign res_o.strength = out_q.strength;
  assign res_o.temperature = out_q.temperature;
  assign res_o.frame_good = out_q.frame_good;

endmodule

// File: dv/tb_lidar_frame_parser.sv
// Self-checking testbench of the lidar frame parser: directed, random and header-write items.
`timescale 1ns / 100ps

module tb_lidar_frame_parser;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned ItemsPerPhase = 500;
  localparam logic [lfp_pkg::ApbAddrW-1:0] HdrAddr =
    lfp_pkg::ApbAddrW'(4 * lfp_pkg::RegHeader);

  typedef struct packed {
    logic [lfp_pkg::ByteW-1:0] rx;
    logic                      typed;
    lfp_pkg::result_t          res;
  } dir_row_t;

  // Directed bytes with the header at its reset value. Rows that close a frame with an
  // obvious outcome carry the result; the rest are left to the predictor.
  localparam dir_row_t DirTbl [21] = '{
    {8'h00, 1'b0, 49'h0},
    {8'h59, 1'b0, 49'h0},
    {8'h5A, 1'b0, 49'h0},
    {8'h59, 1'b0, 49'h0},
    {8'h59, 1'b0, 49'h0},
    {8'hFF, 1'b0, 49'h0},
    {8'hFF, 1'b0, 49'h0},
    {8'h00, 1'b0, 49'h0},
    {8'h00, 1'b0, 49'h0},
    {8'hFF, 1'b0, 49'h0},
    {8'hFF, 1'b0, 49'h0},
    {8'hAE, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1},
    {8'h59, 1'b0, 49'h0},
    {8'h59, 1'b0, 49'h0},
    {8'h59, 1'b0, 49'h0},
    {8'h59, 1'b0, 49'h0},
    {8'h00, 1'b0, 49'h0},
    {8'h00, 1'b0, 49'h0},
    {8'hFF, 1'b0, 49'h0},
    {8'hFF, 1'b0, 49'h0},
    {8'h63, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lfp_pkg::ApbAddrW-1:0] paddr;
  logic [lfp_pkg::ApbDataW-1:0] pwdata;
  logic [lfp_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  lfp_in_if  rx_if ();
  lfp_out_if res_if ();

  lidar_frame_parser #(
    .FRAME_BYTES(FrameBytes)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state.
  logic [lfp_pkg::ByteW-1:0] hdr_copy;
  lfp_pkg::sync_state_e      sync_q;
  int unsigned               byte_pos;
  logic [lfp_pkg::ByteW-1:0] sum_q;
  logic [lfp_pkg::ByteW-1:0] frame_mem [16];

  lfp_pkg::result_t pending_frames [$];
  logic             row_typed;
  lfp_pkg::result_t row_res;
  int unsigned      src_idle_pct;
  int unsigned      snk_stall_pct;
  int unsigned      cycles;
  int unsigned      errors;
  int unsigned      bytes_in;
  int unsigned      bytes_sent;
  int unsigned      frames_seen;
  int unsigned      frames_good;
  logic [lfp_pkg::ByteW-1:0] last_hdr;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic bit parse_rx_byte(input logic [lfp_pkg::ByteW-1:0] b,
                                       output lfp_pkg::result_t res);
    int unsigned pos;
    bit done;
    res = '0;
    done = 1'b0;
    case (sync_q)
      lfp_pkg::SyncHunt1: begin
        byte_pos = 0;
        if (b == hdr_copy) sync_q = lfp_pkg::SyncHunt2;
      end
      lfp_pkg::SyncHunt2: begin
        sync_q = (b == hdr_copy) ? lfp_pkg::SyncCollect : lfp_pkg::SyncHunt1;
      end
      default: ;
    endcase
    pos = byte_pos % 16;
    frame_mem[pos] = b;
    if (pos == 0) begin
      sum_q = b;
    end else if (pos < FrameBytes - 1) begin
      sum_q = sum_q + b;
    end
    byte_pos = (pos + 1) % 16;
    if (pos + 1 >= FrameBytes) begin
      if (sync_q == lfp_pkg::SyncCollect) begin
        done = 1'b1;
        res.frame_good = (sum_q == b);
        if (res.frame_good) begin
          res.distance = {frame_mem[lfp_pkg::DistOfs + 1], frame_mem[lfp_pkg::DistOfs]};
          res.strength = {frame_mem[lfp_pkg::StrOfs + 1], frame_mem[lfp_pkg::StrOfs]};
          res.temperature = {frame_mem[lfp_pkg::TempHiOfs], frame_mem[lfp_pkg::TempOfs]};
        end
      end
      sync_q = lfp_pkg::SyncHunt1;
      byte_pos = 0;
    end
    return done;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    lfp_pkg::result_t made;
    lfp_pkg::result_t want;
    bit               produced;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d frames pending.", cycles,
               pending_frames.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        bytes_in++;
        produced = parse_rx_byte(rx_if.rx_byte, made);
        if (produced && !row_typed) pending_frames.push_back(made);
        if (row_typed) pending_frames.push_back(row_res);
      end
      if (res_if.valid && res_if.ready) begin
        frames_seen++;
        if (res_if.frame_good) frames_good++;
        if (pending_frames.size() == 0) begin
          note_mismatch("frame result with nothing pending");
        end else begin
          want = pending_frames.pop_front();
          if (res_if.distance !== want.distance)
            note_mismatch($sformatf("distance %h, expected %h", res_if.distance, want.distance));
          if (res_if.strength !== want.strength)
            note_mismatch($sformatf("strength %h, expected %h", res_if.strength, want.strength));
          if (res_if.temperature !== want.temperature)
            note_mismatch($sformatf("temperature %h, expected %h", res_if.temperature,
                                    want.temperature));
          if (res_if.frame_good !== want.frame_good)
            note_mismatch($sformatf("frame_good %b, expected %b", res_if.frame_good,
                                    want.frame_good));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_rx(input logic [lfp_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    bytes_sent++;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [lfp_pkg::ByteW-1:0] pick_payload();
    case ($urandom_range(7))
      0: return hdr_copy;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input bit intact);
    logic [lfp_pkg::ByteW-1:0] sum;
    logic [lfp_pkg::ByteW-1:0] b;
    sum = '0;
    for (int unsigned i = 0; i < FrameBytes - 1; i++) begin
      b = (i < 2) ? hdr_copy : pick_payload();
      sum = sum + b;
      send_rx(b);
    end
    send_rx(intact ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(1'b1);
      end else if (pick < 82) begin
        send_frame(1'b0);
      end else if (pick < 91) begin
        send_rx(hdr_copy);
        send_rx(hdr_copy ^ 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)));
      end
    end
    rx_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_header(input logic [lfp_pkg::ByteW-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= HdrAddr;
    pwdata <= {{(lfp_pkg::ApbDataW - lfp_pkg::ByteW){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    hdr_copy = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_header();
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= HdrAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(lfp_pkg::ApbDataW - lfp_pkg::ByteW){1'b0}}, hdr_copy})
      note_mismatch($sformatf("header register read %h, expected %h", prdata, hdr_copy));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_typed = 1'b0;
    row_res = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    cycles = 0;
    errors = 0;
    bytes_in = 0;
    bytes_sent = 0;
    frames_seen = 0;
    frames_good = 0;
    hdr_copy = lfp_pkg::HeaderReset;
    sync_q = lfp_pkg::SyncHunt1;
    byte_pos = 0;
    sum_q = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_header();

    foreach (DirTbl[i]) begin
      row_typed = DirTbl[i].typed;
      row_res = DirTbl[i].res;
      send_rx(DirTbl[i].rx);
    end
    row_typed = 1'b0;

    // A header change while a frame is being collected must not disturb that frame.
    send_rx(8'h59);
    send_rx(8'h59);
    send_rx(8'h12);
    send_rx(8'h34);
    rx_if.valid <= 1'b0;
    settle();
    write_header(8'hFF);
    check_header();
    send_rx(8'h56);
    send_rx(8'h78);
    send_rx(8'h9A);
    send_rx(8'hBC);
    send_rx(8'h1C);
    rx_if.valid <= 1'b0;
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 46 : 0;
      snk_stall_pct = (ph == 0) ? 46 : (ph == 1) ? 6 : 0;
      run_random(ItemsPerPhase);
      settle();
      if (ph < 2) begin
        write_header((ph == 0) ? 8'h00 : 8'($urandom_range(1, 254)));
        check_header();
      end
    end
    last_hdr = hdr_copy;

    $display("Checked %0d frame results (%0d with a good checksum) from %0d received bytes.",
             frames_seen, frames_good, bytes_in);
    $display("Headers 0x59, 0xFF, 0x00 and 0x%h were used, one written mid-frame.", last_hdr);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
